@@ src/sha_pkg.sv @@
// Shared types, constants and the rotate function for the SHA-256 stream hash.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  typedef enum logic [1:0] {
    OP_ABSORB        = 2'd0,
    OP_ABSORB_FINISH = 2'd1,
    OP_FINISH        = 2'd2,
    OP_NONE          = 2'd3
  } op_t;

  // Request passed from front to back through the queue.
  typedef struct packed {
    logic       absorb;
    logic       finish;
    logic [7:0] data;
  } req_t;

  localparam int QueueDepth = 4;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ src/sha256_stream_hash_unit.sv @@
// Top level of the streaming SHA-256 hash unit.
// Absorb: each byte is written into the block buffer; a full block then goes through compression.
// Finish: pad, length, compression per block (one or two), then 8 digest words.
// Engine: a single shared round engine; requests wait in the queue while it is busy.
// Reset: synchronous active-low rst_n loads initial hash, clears counts and queue.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hash_unit
  import sha_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  logic req_valid, req_ready;
  req_t req;

  sha_front #(.Depth(Depth)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_data_byte,
    .req_valid, .req_ready, .req
  );

  sha_back u_back (
    .clk, .rst_n, .req_valid, .req_ready, .req,
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
  );
endmodule
`default_nettype wire

@@ src/sha_front.sv @@
// Front end: classifies input operations into queued requests.
`timescale 1ns / 1ps
`default_nettype none
module sha_front
  import sha_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_data_byte,
  output logic            req_valid,
  input  wire logic       req_ready,
  output req_t            req
);
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  req_t           mem_r [Depth];
  logic [Aw-1:0]  wp_r, rp_r;
  logic [Aw:0]    cnt_r;
  logic           push, pop;
  req_t           cls;
  op_t            op;

  assign op       = op_t'(in_operation);
  assign in_ready = (cnt_r != (Aw+1)'(Depth));
  assign req_valid = (cnt_r != '0);
  assign req       = mem_r[rp_r];
  assign pop       = req_valid && req_ready;

  always_comb begin
    cls = '{absorb: 1'b0, finish: 1'b0, data: in_data_byte};
    unique case (op)
      OP_ABSORB:        cls.absorb = 1'b1;
      OP_ABSORB_FINISH: begin cls.absorb = 1'b1; cls.finish = 1'b1; end
      OP_FINISH:        cls.finish = 1'b1;
      default:          ;
    endcase
  end

  // unused operation code is dropped here
  assign push = in_valid && in_ready && (op != OP_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == Aw'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == Aw'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end
endmodule
`default_nettype wire

@@ src/sha_back.sv @@
// Back end: block buffer, padding, round engine and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha_back
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_ROUND, S_ADD, S_EMIT
  } state_t;

  state_t        state_r;
  logic [31:0]   w_r [16];     // message schedule window, also block buffer
  logic [31:0]   h_r [8];
  logic [31:0]   v_r [8];
  logic [5:0]    cnt_r;        // bytes in block
  logic [63:0]   bits_r;
  logic [63:0]   total_r;
  logic [5:0]    rnd_r;
  logic          fin_r;        // finishing: last compress ends message
  logic          lenblk_r;     // block under compression holds length
  logic          padded_r;     // 0x80 byte already placed for this message
  logic [2:0]    idx_r;

  logic [31:0]   wt, wnew, s0, s1, t1, t2;
  logic [3:0]    wi;
  logic [1:0]    bi;

  assign req_ready = (state_r == S_IDLE);
  assign wi        = cnt_r[5:2];
  assign bi        = cnt_r[1:0];

  assign s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = s1 + w_r[9] + s0 + w_r[0];
  assign wt   = w_r[0];
  assign t1   = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
              + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[rnd_r] + wt;
  assign t2   = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
              + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign out_valid       = (state_r == S_EMIT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      bits_r   <= '0;
      fin_r    <= 1'b0;
      lenblk_r <= 1'b0;
      padded_r <= 1'b0;
      idx_r    <= '0;
      rnd_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[i];
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            fin_r    <= req.finish;
            padded_r <= 1'b0;
            if (req.absorb) begin
              w_r[wi][8*(3-bi) +: 8] <= req.data;
              cnt_r <= cnt_r + 6'd1;
              if (cnt_r == 6'd63) begin
                total_r <= bits_r + 64'd512;
                bits_r  <= bits_r + 64'd512;
                lenblk_r <= 1'b0;
                for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
                rnd_r   <= '0;
                state_r <= S_ROUND;
              end else if (req.finish) begin
                total_r <= bits_r + {55'd0, cnt_r + 6'd1, 3'd0};
                state_r <= S_PAD;
              end
            end else if (req.finish) begin
              total_r <= bits_r + {55'd0, cnt_r, 3'd0};
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // write 0x80 at cnt, zero the rest of its word and later words
          for (int i = 0; i < 16; i++) begin
            if (4'(i) > wi) w_r[i] <= '0;
          end
          w_r[wi] <= (w_r[wi] & ~(32'hffffffff >> (8*bi)))
                   | (32'h80000000 >> (8*bi));
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          rnd_r    <= '0;
          padded_r <= 1'b1;
          if (cnt_r > 6'd55) begin
            lenblk_r <= 1'b0;
            state_r  <= S_ROUND;
          end else begin
            state_r <= S_LEN;
          end
          cnt_r <= '0;
        end
        S_LEN: begin
          w_r[14]  <= total_r[63:32];
          w_r[15]  <= total_r[31:0];
          lenblk_r <= 1'b1;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          rnd_r    <= '0;
          state_r  <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (!fin_r) begin
            state_r <= S_IDLE;
          end else if (lenblk_r) begin
            idx_r   <= '0;
            state_r <= S_EMIT;
          end else if (!padded_r) begin
            // full block ended the message: padding opens a fresh block
            state_r <= S_PAD;
          end else begin
            // pad overflowed: next block is zeros plus length
            for (int i = 0; i < 14; i++) w_r[i] <= '0;
            state_r <= S_LEN;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[i];
              bits_r   <= '0;
              cnt_r    <= '0;
              lenblk_r <= 1'b0;
              state_r  <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sim/sha256_stream_hash_unit_tb.sv @@
// Testbench for the streaming SHA-256 hash unit: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps
module sha256_stream_hash_unit_tb;
  import sha_pkg::*;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hash_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  byte_req_t   pending_reqs[$];
  digest_t     expected_digests[$];
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  logic [5:0]  fill;
  logic [63:0] bit_count;
  int          errors;
  int          cycles;
  int          in_gap;
  int          out_gap;
  bit          stim_done;
  logic        in_taken;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic hash_request(byte_req_t r);
    logic [63:0] total;
    int pos;
    digest_t d;
    if (r.op == OP_NONE) return;
    if (r.op != OP_FINISH) begin
      blk[fill] = r.data;
      fill = fill + 6'd1;
      if (fill == 0) begin
        compress();
        bit_count += 64'd512;
      end
    end
    if (r.op == OP_ABSORB) return;
    total = bit_count + 64'(fill) * 8;
    pos = fill;
    blk[pos++] = 8'h80;
    if (pos > 56) begin
      while (pos < 64) blk[pos++] = 8'h00;
      compress();
      pos = 0;
    end
    while (pos < 56) blk[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d = '{word: chain[i], index: 3'(i), last: (i == 7)};
      expected_digests = {expected_digests, d};
    end
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    fill = 0;
    bit_count = 0;
  endtask

  task automatic add_req(logic [1:0] op, logic [7:0] data);
    byte_req_t r;
    r = '{op: op, data: data};
    pending_reqs = {pending_reqs, r};
  endtask

  // Message of len bytes, closed with absorb-finish or a bare finish.
  task automatic add_message(int len, bit bare_finish);
    for (int i = 0; i < len; i++)
      add_req((!bare_finish && i == len - 1) ? OP_ABSORB_FINISH : OP_ABSORB,
              8'($urandom));
    if (bare_finish || len == 0) add_req(OP_FINISH, 8'($urandom));
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    int n;
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    for (int i = 0; i < 64; i++) blk[i] = 0;
    fill = 0;
    bit_count = 0;
    errors = 0;
    stim_done = 0;
    // directed: empty, one byte extremes, unused op, pad boundaries
    add_req(OP_FINISH, 8'hff);
    add_req(OP_ABSORB_FINISH, 8'h00);
    add_req(OP_ABSORB_FINISH, 8'hff);
    add_req(OP_NONE, 8'h5a);
    add_req(OP_ABSORB, 8'ha5);
    add_req(OP_NONE, 8'hff);
    add_req(OP_ABSORB_FINISH, 8'h3c);
    add_message(55, 0);
    add_message(56, 1);
    add_message(64, 0);
    add_message(63, 1);
    n = 0;
    while (n < 160) begin
      int len;
      case ($urandom_range(0, 9))
        0: len = $urandom_range(54, 66);
        1: len = $urandom_range(100, 140);
        default: len = $urandom_range(0, 20);
      endcase
      add_message(len, $urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) add_req(OP_NONE, 8'($urandom));
      n += len + 1;
    end
    stim_done = 1;
  end

  // acceptance is decided by the values just before the rising edge
  always @(posedge clk) in_taken <= in_valid && in_ready;

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_gap <= pick_gap();
    end else if (in_valid && !in_taken) begin
      // hold request
    end else begin
      if (in_valid) begin
        hash_request(pending_reqs.pop_front());
      end
      if (in_gap > 0 || pending_reqs.size() == 0) begin
        in_valid <= 0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        in_valid <= 1;
        in_operation <= pending_reqs[0].op;
        in_data_byte <= pending_reqs[0].data;
        in_gap <= pick_gap();
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (out_gap > 0) begin
      out_ready <= 0;
      out_gap <= out_gap - 1;
    end else begin
      out_ready <= 1;
      if (out_valid && out_ready) out_gap <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_digests.size() == 0) begin
        $error("unexpected digest word %h", out_digest_word);
        errors++;
      end else begin
        e = expected_digests.pop_front();
        if (out_digest_word !== e.word) begin
          $error("digest_word expected %h got %h", e.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== e.index) begin
          $error("word_index expected %0d got %0d", e.index, out_word_index);
          errors++;
        end
        if (out_last_word !== e.last) begin
          $error("last_word expected %0d got %0d", e.last, out_last_word);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_operation = OP_ABSORB;
    in_data_byte = 0;
    out_ready = 0;
    out_gap = 0;
    in_gap = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (stim_done && rst_n && pending_reqs.size() == 0 && !in_valid &&
          expected_digests.size() == 0) begin
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_digests.size() == 0) begin
          $display("ALL CHECKS PASSED");
        end else begin
          $display("CHECKS FAILED");
        end
        $finish;
      end
    end
  end

endmodule
